### hdl/rpwm_pkg.sv
// Shared constants, types and a helper function for the ring prefetch window manager.
package rpwm_pkg;

	localparam int unsigned SPB_LOG2     = 7;
	localparam int unsigned BUF_BLOCKS   = 64;
	localparam int unsigned CACHE_BLOCKS = 16;

	localparam int unsigned IDX_W       = 16;
	localparam int unsigned BLK_W       = $clog2(BUF_BLOCKS + 2);
	localparam int unsigned BNUM_W      = 6;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned RDB_W       = IDX_W - SPB_LOG2;
	localparam int unsigned FLAG_WORDS  = (BUF_BLOCKS + 31) / 32;
	localparam int unsigned WSEL_W      = (FLAG_WORDS > 1) ? $clog2(FLAG_WORDS) : 1;
	localparam int unsigned BUF_SAMPLES = BUF_BLOCKS << SPB_LOG2;
	localparam int unsigned DATA_IN_W   = 32;
	localparam int unsigned DATA_OUT_W  = 104;

	typedef logic [BLK_W-1:0] blk_t;
	typedef logic [RDB_W-1:0] rdb_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic {
		ACT_UPDATE = 1'b0,
		ACT_CLEAR  = 1'b1
	} action_t;

	typedef struct packed {
		blk_t                            head;
		blk_t                            tail;
		cnt_t                            count;
		logic [FLAG_WORDS-1:0][31:0]     flags;
		logic                            err;
	} win_state_t;

	typedef struct packed {
		logic              skipped;
		logic [IDX_W-1:0]  write_index_out;
		logic              remove_valid;
		logic [BNUM_W-1:0] remove_block;
		logic [31:0]       remove_flag_word;
		logic              add_valid;
		logic [BNUM_W-1:0] add_block;
		logic [31:0]       add_flag_word;
		cnt_t              fill_level;
		logic              error_now;
	} win_result_t;

	localparam blk_t EMPTY_BLK = BLK_W'(BUF_BLOCKS);

	localparam win_state_t IDLE_STATE = '{
		head:  EMPTY_BLK,
		tail:  EMPTY_BLK,
		count: '0,
		flags: '0,
		err:   1'b0
	};

	// Step to the following block of the ring, wrapping to block zero.
	function automatic blk_t next_blk(input blk_t b);
		blk_t n;
		n = b + blk_t'(1);
		return (n >= EMPTY_BLK) ? blk_t'(0) : n;
	endfunction

endpackage

### hdl/ring_prefetch_window_manager_top.sv
// Top level of the ring prefetch window manager: stream ports, pipeline and state registers.
//
//  Channel  Direction  Handshake            Payload
//  s_*      in         s_tvalid/s_tready    tuser: action; tdata: write_index, read_index
//  m_*      out        m_tvalid/m_tready    tuser: skipped; tdata: window update result
//
// Every input beat yields exactly one output beat. A beat is captured in an input
// register, its tick is evaluated by the step logic while it waits there, and the
// result lands in the output register; one beat is taken per cycle while the output
// side keeps up. The window state updates as a beat moves from the input register
// to the output register. When the output register is full and not taken, a beat in
// the input register holds there and s_tready drops. Reset clears the window to
// empty (head and tail at the empty marker, no flags, no error).
module ring_prefetch_window_manager_top
	import rpwm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_IN_W-1:0]  s_tdata,   // write_index[15:0], read_index[31:16]
	input  logic [0:0]            s_tuser,   // action[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_OUT_W-1:0] m_tdata,   // write_index_out, remove_valid, remove_block,
	                                         // remove_flag_word, add_valid, add_block,
	                                         // add_flag_word, fill_level, error_now, zero pad
	output logic [0:0]            m_tuser    // skipped[0]
);

	logic             valid_s1;
	action_t          action_s1;
	logic [IDX_W-1:0] widx_s1;
	logic [IDX_W-1:0] ridx_s1;
	logic             advance;
	logic             s_accept;
	win_state_t       state_q;
	win_state_t       state_nxt;
	win_result_t      res_comb;
	win_result_t      res_q;
	logic             out_valid_q;

	// The input register moves on whenever the output register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			action_s1 <= action_t'(s_tuser[0]);
			widx_s1   <= s_tdata[IDX_W-1:0];
			ridx_s1   <= s_tdata[2*IDX_W-1:IDX_W];
		end
	end

	rpwm_step u_step (
		.cur         (state_q),
		.action      (action_s1),
		.write_index (widx_s1),
		.read_index  (ridx_s1),
		.nxt         (state_nxt),
		.res         (res_comb)
	);

	// Window state commits only when a beat leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE_STATE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.skipped;
	assign m_tdata  = {4'b0000,
	                   res_q.error_now,
	                   res_q.fill_level,
	                   res_q.add_flag_word,
	                   res_q.add_block,
	                   res_q.add_valid,
	                   res_q.remove_flag_word,
	                   res_q.remove_block,
	                   res_q.remove_valid,
	                   res_q.write_index_out};

endmodule

### hdl/rpwm_step.sv
// Next-state and result logic for one tick of the prefetch window.
module rpwm_step
	import rpwm_pkg::*;
(
	input  win_state_t        cur,
	input  action_t           action,
	input  logic [IDX_W-1:0]  write_index,
	input  logic [IDX_W-1:0]  read_index,
	output win_state_t        nxt,
	output win_result_t       res
);

	rdb_t                  rd_blk;
	rdb_t                  wr_blk;
	blk_t                  hn;
	logic                  outside;
	logic [WSEL_W-1:0]     wsel;

	always_comb begin
		nxt     = cur;
		res     = '0;
		rd_blk  = read_index[IDX_W-1:SPB_LOG2];
		wr_blk  = write_index[IDX_W-1:SPB_LOG2];
		hn      = '0;
		outside = 1'b0;
		wsel    = '0;
		if (action == ACT_CLEAR) begin
			nxt = IDLE_STATE;
		end else if ({1'b0, write_index} >= (IDX_W + 1)'(BUF_SAMPLES)) begin
			res.skipped = 1'b1;
		end else begin
			res.write_index_out = write_index;
			// Retire the tail once the reader has moved past it.
			if (rd_blk != RDB_W'(cur.tail) && cur.count != '0) begin
				if (cur.tail < EMPTY_BLK) begin
					wsel = cur.tail[5 +: WSEL_W];
					nxt.flags[wsel][cur.tail[4:0]] = 1'b0;
					nxt.count = cur.count - cnt_t'(1);
					res.remove_valid     = 1'b1;
					res.remove_block     = cur.tail[BNUM_W-1:0];
					res.remove_flag_word = nxt.flags[wsel];
				end
				nxt.tail = next_blk(cur.tail);
			end
			if (nxt.count < cnt_t'(CACHE_BLOCKS)) begin
				hn = next_blk(cur.head);
				if (RDB_W'(hn) != wr_blk) begin
					wsel = hn[5 +: WSEL_W];
					nxt.flags[wsel][hn[4:0]] = 1'b1;
					nxt.count = nxt.count + cnt_t'(1);
					nxt.head  = hn;
					res.add_valid     = 1'b1;
					res.add_block     = hn[BNUM_W-1:0];
					res.add_flag_word = nxt.flags[wsel];
				end
				if (!cur.err && rd_blk < RDB_W'(BUF_BLOCKS) && nxt.tail < EMPTY_BLK &&
				    nxt.head < EMPTY_BLK) begin
					if (nxt.head >= nxt.tail)
						outside = (rd_blk < RDB_W'(nxt.tail)) || (rd_blk > RDB_W'(nxt.head));
					else
						outside = (rd_blk < RDB_W'(nxt.tail)) && (rd_blk > RDB_W'(nxt.head));
					if (outside) begin
						nxt.err       = 1'b1;
						res.error_now = 1'b1;
					end
				end
			end
			res.fill_level = nxt.count;
		end
	end

endmodule
